@@ rtl/core/otts_pkg.sv @@
// Shared types, codes and default sizes for the ordered task table.
package otts_pkg;

  // Field widths of the transaction payloads.
  localparam int REQ_W   = 2;
  localparam int INDEX_W = 7;
  localparam int TID_W   = 16;
  localparam int TLEN_W  = 16;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 7;
  localparam int TOTAL_W = 22;
  localparam int LARGE_W = 16;

  // Default sizes handed to the top level parameters.
  localparam int CAPACITY_DEF    = 64;
  localparam int LENGTH_BITS_DEF = 16;
  localparam int ID_BITS_DEF     = 16;

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_APPEND  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_INSERT  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_DEL_POS = 2'd2;
  localparam logic [REQ_W-1:0] REQ_DEL_ID  = 2'd3;

  // Status codes.
  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_BAD_POS = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;
  localparam logic [STAT_W-1:0] ST_NO_ID   = 2'd3;

  // Operation broadcast to every cell of the row.
  typedef logic [1:0] cell_op_t;
  localparam cell_op_t OP_NONE    = 2'd0;
  localparam cell_op_t OP_INSERT  = 2'd1;
  localparam cell_op_t OP_DEL_POS = 2'd2;
  localparam cell_op_t OP_DEL_HIT = 2'd3;

  // Input transaction payload.
  typedef struct packed {
    logic [REQ_W-1:0]   req_type;
    logic [INDEX_W-1:0] entry_index;
    logic [TID_W-1:0]   task_id;
    logic [TLEN_W-1:0]  task_length;
  } in_item_t;

  // Result transaction payload.
  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [COUNT_W-1:0] entry_count;
    logic [TOTAL_W-1:0] length_total;
    logic [LARGE_W-1:0] largest_length;
  } out_item_t;

endpackage

@@ rtl/core/otts_cell.sv @@
// One table cell: holds one entry and carries the sum, max and match chains.
module otts_cell #(
  parameter int ID_BITS     = otts_pkg::ID_BITS_DEF,
  parameter int LENGTH_BITS = otts_pkg::LENGTH_BITS_DEF,
  parameter int SUM_W       = 22,
  parameter int IDX_W       = 6,
  parameter int INDEX       = 0
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  otts_pkg::cell_op_t     op_kind,
  input  logic [IDX_W-1:0]       op_pos,
  input  logic [ID_BITS-1:0]     new_id,
  input  logic [LENGTH_BITS-1:0] new_len,
  input  logic [ID_BITS-1:0]     key,
  input  logic                   lo_valid,
  input  logic [ID_BITS-1:0]     lo_id,
  input  logic [LENGTH_BITS-1:0] lo_len,
  input  logic                   hi_valid,
  input  logic [ID_BITS-1:0]     hi_id,
  input  logic [LENGTH_BITS-1:0] hi_len,
  input  logic [SUM_W-1:0]       chain_sum_in,
  input  logic [LENGTH_BITS-1:0] chain_max_in,
  input  logic                   chain_hit_in,
  output logic                   valid_o,
  output logic [ID_BITS-1:0]     id_o,
  output logic [LENGTH_BITS-1:0] len_o,
  output logic [SUM_W-1:0]       chain_sum_o,
  output logic [LENGTH_BITS-1:0] chain_max_o,
  output logic                   chain_hit_o
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  logic                   valid_r, valid_nxt;
  logic [ID_BITS-1:0]     id_r, id_nxt;
  logic [LENGTH_BITS-1:0] len_r, len_nxt;
  logic [SUM_W-1:0]       sum_r;
  logic [LENGTH_BITS-1:0] max_r;
  logic                   hit_r;
  logic [LENGTH_BITS-1:0] my_len;

  // Choose the next contents: hold, take a neighbor, or take the new entry.
  always_comb begin
    valid_nxt = valid_r;
    id_nxt    = id_r;
    len_nxt   = len_r;
    case (op_kind)
      otts_pkg::OP_INSERT: begin
        if (MY_IDX > op_pos) begin
          valid_nxt = lo_valid;
          id_nxt    = lo_id;
          len_nxt   = lo_len;
        end else if (MY_IDX == op_pos) begin
          valid_nxt = 1'b1;
          id_nxt    = new_id;
          len_nxt   = new_len;
        end
      end
      otts_pkg::OP_DEL_POS: begin
        if (MY_IDX >= op_pos) begin
          valid_nxt = hi_valid;
          id_nxt    = hi_id;
          len_nxt   = hi_len;
        end
      end
      otts_pkg::OP_DEL_HIT: begin
        if (hit_r) begin
          valid_nxt = hi_valid;
          id_nxt    = hi_id;
          len_nxt   = hi_len;
        end
      end
      default: begin
      end
    endcase
  end

  // Entry storage; only the valid bit needs a reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r  <= id_nxt;
    len_r <= len_nxt;
  end

  // Prefix chains: running sum, running max and "a match at or below here".
  assign my_len = valid_r ? len_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      max_r <= '0;
      hit_r <= 1'b0;
    end else begin
      sum_r <= chain_sum_in + SUM_W'(my_len);
      max_r <= (my_len > chain_max_in) ? my_len : chain_max_in;
      hit_r <= chain_hit_in | (valid_r && (id_r == key));
    end
  end

  assign valid_o     = valid_r;
  assign id_o        = id_r;
  assign len_o       = len_r;
  assign chain_sum_o = sum_r;
  assign chain_max_o = max_r;
  assign chain_hit_o = hit_r;

endmodule

@@ rtl/core/ordered_task_table_sum_max_core.sv @@
// Ordered task table: a row of cells that shift in parallel, with sum and max chains.
// Append, insert and a refused position or full check go from EXEC straight to OUT; delete
// at a position waits in SUM, and an unmatched delete by id in FIND, while a chain ripples;
// a matched delete by id waits in FIND, then SUM, as the match chain ripples before the sum chain.
// One request at a time, taken only once the last result loads; a stalled result holds input.
// Synchronous reset empties the table at once: count, sum, max and cell valid bits clear.
module ordered_task_table_sum_max_core #(
  parameter int CAPACITY    = otts_pkg::CAPACITY_DEF,
  parameter int LENGTH_BITS = otts_pkg::LENGTH_BITS_DEF,
  parameter int ID_BITS     = otts_pkg::ID_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  otts_pkg::in_item_t in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output otts_pkg::out_item_t out_data
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int SUM_W = LENGTH_BITS + CNT_W;
  localparam int CMP_W = (CNT_W > otts_pkg::INDEX_W) ? CNT_W : otts_pkg::INDEX_W;
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_FIND = 3'd2;
  localparam logic [2:0] S_SUM  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]                 state_r, state_nxt;
  otts_pkg::in_item_t         req_r;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic [SUM_W-1:0]           sum_r, sum_nxt;
  logic [LENGTH_BITS-1:0]     max_r, max_nxt;
  logic [otts_pkg::STAT_W-1:0] status_r, status_nxt;
  logic [CNT_W-1:0]           scan_r, scan_nxt;
  otts_pkg::out_item_t        out_r;
  logic                       out_valid_r;
  logic                       load_out;

  otts_pkg::cell_op_t         op_kind;
  logic [IDX_W-1:0]           op_pos;
  logic [ID_BITS-1:0]         req_id;
  logic [LENGTH_BITS-1:0]     req_len;
  logic [CMP_W-1:0]           pos_cmp;
  logic [CMP_W-1:0]           cnt_cmp;

  logic                   cell_valid [CAPACITY];
  logic [ID_BITS-1:0]     cell_id    [CAPACITY];
  logic [LENGTH_BITS-1:0] cell_len   [CAPACITY];
  logic [SUM_W-1:0]       cell_sum   [CAPACITY];
  logic [LENGTH_BITS-1:0] cell_max   [CAPACITY];
  logic                   cell_hit   [CAPACITY];

  assign req_id  = ID_BITS'(req_r.task_id);
  assign req_len = LENGTH_BITS'(req_r.task_length);
  assign pos_cmp = CMP_W'(req_r.entry_index);
  assign cnt_cmp = CMP_W'(cnt_r);

  // Input side takes a transaction only between requests.
  assign in_stall = (state_r != S_IDLE);
  assign load_out = !out_valid_r || !out_stall;

  // Request sequencer.
  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    sum_nxt    = sum_r;
    max_nxt    = max_r;
    status_nxt = status_r;
    scan_nxt   = scan_r;
    op_kind    = otts_pkg::OP_NONE;
    op_pos     = IDX_W'(req_r.entry_index);
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        status_nxt = otts_pkg::ST_OK;
        scan_nxt   = '0;
        state_nxt  = S_OUT;
        case (req_r.req_type) inside
          otts_pkg::REQ_APPEND, otts_pkg::REQ_INSERT: begin
            if ((req_r.req_type == otts_pkg::REQ_INSERT) && (pos_cmp > cnt_cmp)) begin
              status_nxt = otts_pkg::ST_BAD_POS;
            end else if (cnt_r >= CAP_CNT) begin
              status_nxt = otts_pkg::ST_FULL;
            end else begin
              op_kind = otts_pkg::OP_INSERT;
              if (req_r.req_type == otts_pkg::REQ_APPEND) begin
                op_pos = IDX_W'(cnt_r);
              end
              cnt_nxt = cnt_r + CNT_W'(1);
              sum_nxt = sum_r + SUM_W'(req_len);
              max_nxt = (req_len > max_r) ? req_len : max_r;
            end
          end
          otts_pkg::REQ_DEL_POS: begin
            if (pos_cmp >= cnt_cmp) begin
              status_nxt = otts_pkg::ST_BAD_POS;
            end else begin
              op_kind   = otts_pkg::OP_DEL_POS;
              cnt_nxt   = cnt_r - CNT_W'(1);
              state_nxt = S_SUM;
            end
          end
          default: begin
            state_nxt = S_FIND;
          end
        endcase
      end
      S_FIND: begin
        // The match chain has settled over the whole row once the count is reached.
        scan_nxt = scan_r + CNT_W'(1);
        if (scan_r == CAP_CNT) begin
          scan_nxt = '0;
          if (cell_hit[CAPACITY-1]) begin
            op_kind   = otts_pkg::OP_DEL_HIT;
            cnt_nxt   = cnt_r - CNT_W'(1);
            state_nxt = S_SUM;
          end else begin
            status_nxt = otts_pkg::ST_NO_ID;
            state_nxt  = S_OUT;
          end
        end
      end
      S_SUM: begin
        // Wait for the sum and max chains to ripple through the shifted row.
        scan_nxt = scan_r + CNT_W'(1);
        if (scan_r == CAP_CNT) begin
          sum_nxt   = cell_sum[CAPACITY-1];
          max_nxt   = cell_max[CAPACITY-1];
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r    <= '0;
      sum_r    <= '0;
      max_r    <= '0;
      status_r <= otts_pkg::ST_OK;
      scan_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      sum_r    <= sum_nxt;
      max_r    <= max_nxt;
      status_r <= status_nxt;
      scan_r   <= scan_nxt;
    end
  end

  // Request capture on an accepted input transaction.
  always_ff @(posedge clk) begin
    if ((state_r == S_IDLE) && in_valid) begin
      req_r <= in_data;
    end
  end

  // Result register; holds until the output transaction completes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == S_OUT) && load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_OUT) && load_out) begin
      out_r.status         <= status_r;
      out_r.entry_count    <= otts_pkg::COUNT_W'(cnt_r);
      out_r.length_total   <= otts_pkg::TOTAL_W'(sum_r);
      out_r.largest_length <= otts_pkg::LARGE_W'(max_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Row of cells; each sees its lower and upper neighbor.
  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic                   lo_valid, hi_valid, hit_in;
    logic [ID_BITS-1:0]     lo_id, hi_id;
    logic [LENGTH_BITS-1:0] lo_len, hi_len, max_in;
    logic [SUM_W-1:0]       sum_in;

    if (k == 0) begin : g_first
      assign lo_valid = 1'b0;
      assign lo_id    = '0;
      assign lo_len   = '0;
      assign sum_in   = '0;
      assign max_in   = '0;
      assign hit_in   = 1'b0;
    end else begin : g_mid
      assign lo_valid = cell_valid[k-1];
      assign lo_id    = cell_id[k-1];
      assign lo_len   = cell_len[k-1];
      assign sum_in   = cell_sum[k-1];
      assign max_in   = cell_max[k-1];
      assign hit_in   = cell_hit[k-1];
    end

    if (k == CAPACITY - 1) begin : g_last
      assign hi_valid = 1'b0;
      assign hi_id    = '0;
      assign hi_len   = '0;
    end else begin : g_up
      assign hi_valid = cell_valid[k+1];
      assign hi_id    = cell_id[k+1];
      assign hi_len   = cell_len[k+1];
    end

    otts_cell #(
      .ID_BITS     (ID_BITS),
      .LENGTH_BITS (LENGTH_BITS),
      .SUM_W       (SUM_W),
      .IDX_W       (IDX_W),
      .INDEX       (k)
    ) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .op_kind      (op_kind),
      .op_pos       (op_pos),
      .new_id       (req_id),
      .new_len      (req_len),
      .key          (req_id),
      .lo_valid     (lo_valid),
      .lo_id        (lo_id),
      .lo_len       (lo_len),
      .hi_valid     (hi_valid),
      .hi_id        (hi_id),
      .hi_len       (hi_len),
      .chain_sum_in (sum_in),
      .chain_max_in (max_in),
      .chain_hit_in (hit_in),
      .valid_o      (cell_valid[k]),
      .id_o         (cell_id[k]),
      .len_o        (cell_len[k]),
      .chain_sum_o  (cell_sum[k]),
      .chain_max_o  (cell_max[k]),
      .chain_hit_o  (cell_hit[k])
    );
  end

endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench for the ordered task table core with running sum and maximum.
module tb_top;
  import otts_pkg::*;

  localparam int CAP        = CAPACITY_DEF;
  localparam int RAND_GOAL  = 930;
  localparam int CALM_TAIL  = 150;
  localparam int HOLD_AT    = 300;
  localparam int HOLD_LEN   = 150;
  localparam int DRAIN_WAIT = 2 * CAP + 20;
  localparam int LIMIT      = 1000000;
  localparam int DIR_N      = 20;

  typedef struct {
    in_item_t  rq;
    bit        typed;
    out_item_t res;
  } dir_row_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  // Predictor copy of the table.
  logic [TID_W-1:0]   tab_ids [CAP];
  logic [TLEN_W-1:0]  tab_lens [CAP];
  int                 tab_count;
  logic [TOTAL_W-1:0] tab_sum;
  logic [LARGE_W-1:0] tab_max;

  out_item_t pending_results [$];
  out_item_t want;
  int        fail_count;
  int        checked;
  int        sent;
  int        status_seen [4];
  int        cycle_cnt;
  bit        calm;
  bit        hold_req;

  // Directed requests; typed results are the ones readable straight from the table contents.
  dir_row_t dir_rows [DIR_N] = '{
    '{{REQ_DEL_POS, 7'd0, 16'h0000, 16'h0000}, 1'b1, {ST_BAD_POS, 7'd0, 22'd0, 16'd0}},
    '{{REQ_DEL_ID, 7'd0, 16'h0000, 16'h0000}, 1'b1, {ST_NO_ID, 7'd0, 22'd0, 16'd0}},
    '{{REQ_INSERT, 7'd1, 16'h0001, 16'h0001}, 1'b1, {ST_BAD_POS, 7'd0, 22'd0, 16'd0}},
    '{{REQ_INSERT, 7'd0, 16'hFFFF, 16'hFFFF}, 1'b1, {ST_OK, 7'd1, 22'd65535, 16'hFFFF}},
    '{{REQ_APPEND, 7'd0, 16'h0000, 16'h0000}, 1'b1, {ST_OK, 7'd2, 22'd65535, 16'hFFFF}},
    '{{REQ_APPEND, 7'd0, 16'h1234, 16'h0001}, 1'b1, {ST_OK, 7'd3, 22'd65536, 16'hFFFF}},
    '{{REQ_INSERT, 7'd3, 16'h00FF, 16'd100}, 1'b0, '0},
    '{{REQ_INSERT, 7'd64, 16'h0002, 16'h0002}, 1'b0, '0},
    '{{REQ_INSERT, 7'd127, 16'hFFFF, 16'hFFFF}, 1'b0, '0},
    '{{REQ_DEL_POS, 7'd127, 16'h0000, 16'h0000}, 1'b0, '0},
    '{{REQ_DEL_POS, 7'd4, 16'h0000, 16'h0000}, 1'b0, '0},
    '{{REQ_APPEND, 7'd0, 16'h1234, 16'h0007}, 1'b0, '0},
    '{{REQ_DEL_ID, 7'd0, 16'h1234, 16'h0000}, 1'b0, '0},
    '{{REQ_DEL_ID, 7'd0, 16'hBEEF, 16'h0000}, 1'b0, '0},
    '{{REQ_DEL_POS, 7'd0, 16'h0000, 16'h0000}, 1'b0, '0},
    '{{REQ_INSERT, 7'd1, 16'h5555, 16'hAAAA}, 1'b0, '0},
    '{{REQ_DEL_POS, 7'd3, 16'h0000, 16'h0000}, 1'b0, '0},
    '{{REQ_DEL_ID, 7'd0, 16'h0000, 16'h0000}, 1'b0, '0},
    '{{REQ_DEL_POS, 7'd1, 16'h0000, 16'h0000}, 1'b0, '0},
    '{{REQ_DEL_POS, 7'd0, 16'h0000, 16'h0000}, 1'b1, {ST_OK, 7'd0, 22'd0, 16'd0}}
  };

  ordered_task_table_sum_max_core uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Put a task at a position, moving later entries up by one.
  function automatic void place_entry(int pos, logic [TID_W-1:0] id, logic [TLEN_W-1:0] len);
    for (int k = tab_count; k > pos; k--) begin
      tab_ids[k]  = tab_ids[k-1];
      tab_lens[k] = tab_lens[k-1];
    end
    tab_ids[pos]  = id;
    tab_lens[pos] = len;
    tab_count++;
    tab_sum = tab_sum + len;
    if (len > tab_max) tab_max = len;
  endfunction

  // Remove the entry at a position, close the gap and rescan for the largest length.
  function automatic void drop_entry(int pos);
    tab_sum = tab_sum - tab_lens[pos];
    for (int k = pos; k + 1 < tab_count; k++) begin
      tab_ids[k]  = tab_ids[k+1];
      tab_lens[k] = tab_lens[k+1];
    end
    tab_count--;
    tab_max = '0;
    for (int k = 0; k < tab_count; k++) begin
      if (tab_lens[k] > tab_max) tab_max = tab_lens[k];
    end
  endfunction

  // Apply one request to the predictor table and return the result it should report.
  function automatic out_item_t apply_request(in_item_t rq);
    out_item_t res;
    int        hit;
    res.status = ST_OK;
    hit = -1;
    case (rq.req_type)
      REQ_APPEND: begin
        if (tab_count >= CAP) res.status = ST_FULL;
        else place_entry(tab_count, rq.task_id, rq.task_length);
      end
      REQ_INSERT: begin
        if (rq.entry_index > tab_count) res.status = ST_BAD_POS;
        else if (tab_count >= CAP) res.status = ST_FULL;
        else place_entry(int'(rq.entry_index), rq.task_id, rq.task_length);
      end
      REQ_DEL_POS: begin
        if (rq.entry_index >= tab_count) res.status = ST_BAD_POS;
        else drop_entry(int'(rq.entry_index));
      end
      REQ_DEL_ID: begin
        for (int k = 0; k < tab_count; k++) begin
          if (hit < 0 && tab_ids[k] == rq.task_id) hit = k;
        end
        if (hit < 0) res.status = ST_NO_ID;
        else drop_entry(hit);
      end
      default: ;
    endcase
    res.entry_count    = COUNT_W'(tab_count);
    res.length_total   = tab_sum;
    res.largest_length = tab_max;
    return res;
  endfunction

  // Random request that tends to fill or drain the table, with some unshaped noise mixed in.
  function automatic in_item_t make_request(bit growing);
    in_item_t rq;
    int       pick;
    pick = $urandom_range(0, 99);
    rq.entry_index = INDEX_W'($urandom_range(0, 127));
    if ($urandom_range(0, 2) == 0) rq.task_id = TID_W'($urandom);
    else rq.task_id = TID_W'($urandom_range(0, 7));
    case ($urandom_range(0, 9))
      0:       rq.task_length = '0;
      1:       rq.task_length = '1;
      2, 3, 4: rq.task_length = TLEN_W'($urandom_range(0, 255));
      default: rq.task_length = TLEN_W'($urandom);
    endcase
    if (pick < 20) begin
      rq.req_type = REQ_W'($urandom_range(0, 3));
    end else if (growing) begin
      if (pick < 60) begin
        rq.req_type = REQ_APPEND;
      end else begin
        rq.req_type    = REQ_INSERT;
        rq.entry_index = INDEX_W'($urandom_range(0, tab_count));
      end
    end else if (tab_count == 0) begin
      rq.req_type = (pick < 60) ? REQ_DEL_POS : REQ_DEL_ID;
    end else if (pick < 60) begin
      rq.req_type    = REQ_DEL_POS;
      rq.entry_index = INDEX_W'($urandom_range(0, tab_count - 1));
    end else begin
      rq.req_type = REQ_DEL_ID;
      rq.task_id  = tab_ids[$urandom_range(0, tab_count - 1)];
    end
    return rq;
  endfunction

  // Offer one request transaction, wait for it to be taken, then record what it should return.
  task automatic offer(input in_item_t rq, input bit typed, input out_item_t typed_res);
    out_item_t predicted;
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_data  <= rq;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    predicted = apply_request(rq);
    status_seen[predicted.status]++;
    pending_results.push_back(typed ? typed_res : predicted);
    sent++;
  endtask

  task automatic check_field(input string name, input longint expd, input longint got);
    if (expd != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, expd, got);
      fail_count++;
    end
  endtask

  // Result side: compare every accepted result transaction with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result transaction with no request pending: %p", out_data);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", want.status, out_data.status);
        check_field("entry_count", want.entry_count, out_data.entry_count);
        check_field("length_total", want.length_total, out_data.length_total);
        check_field("largest_length", want.largest_length, out_data.largest_length);
        checked++;
      end
    end
  end

  // Receiver back-pressure: random bursts, one long hold on request, none in the calm tail.
  initial begin
    int run;
    bit level;
    out_stall <= 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        level    = 1'b1;
        run      = HOLD_LEN;
        hold_req = 1'b0;
      end else if (calm) begin
        level = 1'b0;
        run   = 1;
      end else if ($urandom_range(0, 3) == 0) begin
        level = 1'b1;
        run   = $urandom_range(1, 10);
      end else begin
        level = 1'b0;
        run   = $urandom_range(1, 25);
      end
      out_stall <= level;
      repeat (run) @(posedge clk);
    end
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= LIMIT) begin
      $display("ordered_task_table_sum_max_core test failed");
      $finish;
    end
  end

  // Main sequence: reset, directed table, then fill and drain episodes with random content.
  initial begin
    int  target;
    bit  hold_armed;
    fail_count = 0;
    checked    = 0;
    sent       = 0;
    cycle_cnt  = 0;
    calm       = 1'b0;
    hold_req   = 1'b0;
    hold_armed = 1'b0;
    tab_count  = 0;
    tab_sum    = '0;
    tab_max    = '0;
    foreach (status_seen[i]) status_seen[i] = 0;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) offer(dir_rows[i].rq, dir_rows[i].typed, dir_rows[i].res);

    for (int ep = 0; sent < DIR_N + RAND_GOAL; ep++) begin
      calm = (sent >= DIR_N + RAND_GOAL - CALM_TAIL);
      if (!hold_armed && sent >= HOLD_AT) begin
        hold_armed = 1'b1;
        hold_req   = 1'b1;
      end

      // Grow: every third episode runs the table to capacity and pokes at it while full.
      target = (ep % 3 == 0) ? CAP : $urandom_range(4, CAP);
      while (tab_count < target) offer(make_request(1'b1), 1'b0, '0);
      if (target == CAP) begin
        repeat (3) offer(make_request(1'b1), 1'b0, '0);
        offer({REQ_INSERT, INDEX_W'($urandom_range(CAP + 1, 127)), TID_W'($urandom),
               TLEN_W'($urandom)}, 1'b0, '0);
      end

      // Shrink: often all the way down, then a couple of requests against the empty table.
      target = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, tab_count / 2);
      while (tab_count > target) offer(make_request(1'b0), 1'b0, '0);
      if (target == 0) repeat (2) offer(make_request(1'b0), 1'b0, '0);

      // Now and then the sender waits for every outstanding result before going on.
      if (!calm && $urandom_range(0, 3) == 0) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
      end
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Sent %0d requests and checked %0d results in %0d cycles.", sent, checked,
             cycle_cnt);
    $display("Status mix: ok %0d, bad position %0d, full %0d, id not found %0d.",
             status_seen[ST_OK], status_seen[ST_BAD_POS], status_seen[ST_FULL],
             status_seen[ST_NO_ID]);
    if (fail_count == 0) begin
      $display("ordered_task_table_sum_max_core test passed");
    end else begin
      $display("ordered_task_table_sum_max_core test failed");
    end
    $finish;
  end

endmodule
